FILE: hw/rtl/chbd_pkg.sv
// chbd_pkg: shared types, constants and byte classifiers for the chunked body decoder
// no dependencies; used by chbd_step and http_chunked_body_decoder_top
`default_nettype none

package chbd_pkg;

    localparam int SIZE_BITS  = 32;
    localparam int TOTAL_BITS = 33;
    localparam int MAX_BITS   = 32;
    localparam int SUM_BITS   = ((SIZE_BITS > TOTAL_BITS) ? SIZE_BITS : TOTAL_BITS) + 1;

    localparam logic [MAX_BITS-1:0] MAX_BODY_RESET = MAX_BITS'(1048576);

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef enum logic [7:0] {
        PH_START   = 8'b0000_0001,
        PH_DIGITS  = 8'b0000_0010,
        PH_EXT     = 8'b0000_0100,
        PH_LINE_LF = 8'b0000_1000,
        PH_DATA    = 8'b0001_0000,
        PH_DATA_CR = 8'b0010_0000,
        PH_DATA_LF = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_BAD      = 2'd2,
        KIND_LARGE    = 2'd3
    } t_kind;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        t_kind      kind;
    } t_result;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
        end else if (c inside {[8'h41:8'h46]}) begin
            v = c - 8'h37;
        end else begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

    // space, tab, lf, vt, ff
    function automatic logic is_skip_space(input logic [7:0] c);
        return (c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C});
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/chbd_step.sv
// chbd_step: next-state and result logic for one body byte
// depends on chbd_pkg
`default_nettype none

module chbd_step (
    input  wire logic [7:0]                     i_byte,
    input  wire chbd_pkg::t_phase               i_phase,
    input  wire logic [chbd_pkg::SIZE_BITS-1:0]  i_chunk,
    input  wire logic [chbd_pkg::TOTAL_BITS-1:0] i_total,
    input  wire logic [chbd_pkg::MAX_BITS-1:0]   i_max,
    output chbd_pkg::t_phase                    o_phase,
    output logic [chbd_pkg::SIZE_BITS-1:0]       o_chunk,
    output logic [chbd_pkg::TOTAL_BITS-1:0]      o_total,
    output chbd_pkg::t_result                   o_result
);

    logic                             w_hex;
    logic [chbd_pkg::SUM_BITS-1:0]    w_sum;
    logic [chbd_pkg::SIZE_BITS-1:0]   w_dec;

    assign w_hex = chbd_pkg::is_hex(i_byte);
    assign w_sum = chbd_pkg::SUM_BITS'(i_total) + chbd_pkg::SUM_BITS'(i_chunk);
    assign w_dec = i_chunk - chbd_pkg::SIZE_BITS'(1);

    always_comb begin
        o_phase  = i_phase;
        o_chunk  = i_chunk;
        o_total  = i_total;
        o_result = '{valid: 1'b0, out_byte: 8'h00, kind: chbd_pkg::KIND_BYTE};

        case (i_phase)
            chbd_pkg::PH_START, chbd_pkg::PH_DIGITS: begin
                if (w_hex) begin
                    // top nibble in use: one more digit would overflow
                    if (i_chunk[chbd_pkg::SIZE_BITS-1 -: 4] != 4'h0) begin
                        o_result = '{valid: 1'b1, out_byte: 8'h00,
                                     kind: chbd_pkg::KIND_LARGE};
                        o_phase  = chbd_pkg::PH_DONE;
                    end else begin
                        o_chunk = {i_chunk[chbd_pkg::SIZE_BITS-5:0],
                                   chbd_pkg::hex_value(i_byte)};
                        o_phase = chbd_pkg::PH_DIGITS;
                    end
                end else if (i_byte == chbd_pkg::CHAR_CR) begin
                    o_phase = chbd_pkg::PH_LINE_LF;
                end else if (i_phase == chbd_pkg::PH_START
                             && chbd_pkg::is_skip_space(i_byte)) begin
                    o_phase = chbd_pkg::PH_START;
                end else begin
                    o_phase = chbd_pkg::PH_EXT;
                end
            end
            chbd_pkg::PH_EXT: begin
                if (i_byte == chbd_pkg::CHAR_CR) begin
                    o_phase = chbd_pkg::PH_LINE_LF;
                end
            end
            chbd_pkg::PH_LINE_LF: begin
                if (i_byte == chbd_pkg::CHAR_LF) begin
                    if (i_chunk == '0) begin
                        o_result = '{valid: 1'b1, out_byte: 8'h00,
                                     kind: chbd_pkg::KIND_COMPLETE};
                        o_phase  = chbd_pkg::PH_DONE;
                    end else if (w_sum > chbd_pkg::SUM_BITS'(i_max)) begin
                        // also covers a total already above a lowered limit
                        o_result = '{valid: 1'b1, out_byte: 8'h00,
                                     kind: chbd_pkg::KIND_LARGE};
                        o_phase  = chbd_pkg::PH_DONE;
                    end else begin
                        o_total = w_sum[chbd_pkg::TOTAL_BITS-1:0];
                        o_phase = chbd_pkg::PH_DATA;
                    end
                end else if (i_byte != chbd_pkg::CHAR_CR) begin
                    o_phase = chbd_pkg::PH_EXT;
                end
            end
            chbd_pkg::PH_DATA: begin
                o_chunk  = w_dec;
                o_result = '{valid: 1'b1, out_byte: i_byte, kind: chbd_pkg::KIND_BYTE};
                if (w_dec == '0) begin
                    o_phase = chbd_pkg::PH_DATA_CR;
                end
            end
            chbd_pkg::PH_DATA_CR: begin
                if (i_byte != chbd_pkg::CHAR_CR) begin
                    o_result = '{valid: 1'b1, out_byte: 8'h00, kind: chbd_pkg::KIND_BAD};
                    o_phase  = chbd_pkg::PH_DONE;
                end else begin
                    o_phase = chbd_pkg::PH_DATA_LF;
                end
            end
            chbd_pkg::PH_DATA_LF: begin
                if (i_byte != chbd_pkg::CHAR_LF) begin
                    o_result = '{valid: 1'b1, out_byte: 8'h00, kind: chbd_pkg::KIND_BAD};
                    o_phase  = chbd_pkg::PH_DONE;
                end else begin
                    o_phase = chbd_pkg::PH_START;
                    o_chunk = '0;
                end
            end
            default: begin
                // finished: bytes are swallowed
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/http_chunked_body_decoder_top.sv
// http_chunked_body_decoder_top: input register, decode state and result register
// depends on chbd_pkg and chbd_step
//
// Usage: body bytes enter on i_valid / i_data_byte, with o_stall pushing back.
// Each request yields zero or one result on o_valid / o_out_byte / o_kind,
// held until a cycle with i_stall low. Kind 0 carries a payload byte; kinds
// 1 (complete), 2 (bad framing) and 3 (too large) end the body, after which
// all further bytes are taken and dropped until reset.
// A taken byte is held in the input register, then decoded into the result
// register. Throughput: one byte per cycle unless stalled; the decode of a byte
// is a single pass through the step logic, with one 34-bit add and compare for
// the size limit. A stalled result register holds the pending byte in the input
// register, and o_stall rises only when both registers are occupied. Reset
// (i_rst_n low, synchronous) empties both registers, returns the decoder to the
// start of a size line with zero totals and sets the size limit to 1048576. The
// limit is written through i_cfg_wr_en / i_cfg_wr_data; the user must do so
// only while idle, as the block does not enforce this.
`default_nettype none

module http_chunked_body_decoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_kind
);

    logic                              r_in_valid;
    logic [7:0]                        r_in_byte;
    chbd_pkg::t_phase                  r_phase;
    logic [chbd_pkg::SIZE_BITS-1:0]    r_chunk;
    logic [chbd_pkg::TOTAL_BITS-1:0]   r_total;
    logic [chbd_pkg::MAX_BITS-1:0]     r_max;
    logic                              r_out_valid;
    logic [7:0]                        r_out_byte;
    chbd_pkg::t_kind                   r_out_kind;

    chbd_pkg::t_phase                  n_phase;
    logic [chbd_pkg::SIZE_BITS-1:0]    n_chunk;
    logic [chbd_pkg::TOTAL_BITS-1:0]   n_total;
    chbd_pkg::t_result                 w_result;

    logic w_go;
    logic w_take;

    // decode advances whenever the result register is free or draining
    assign w_go   = r_in_valid && (!r_out_valid || !i_stall);
    assign w_take = i_valid && !o_stall;

    assign o_stall    = r_in_valid && !w_go;
    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_kind     = r_out_kind;

    chbd_step u_step (
        .i_byte   (r_in_byte),
        .i_phase  (r_phase),
        .i_chunk  (r_chunk),
        .i_total  (r_total),
        .i_max    (r_max),
        .o_phase  (n_phase),
        .o_chunk  (n_chunk),
        .o_total  (n_total),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= chbd_pkg::PH_START;
            r_chunk     <= '0;
            r_total     <= '0;
            r_max       <= chbd_pkg::MAX_BODY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_go) begin
                r_in_valid <= 1'b0;
            end
            if (w_go) begin
                r_phase     <= n_phase;
                r_chunk     <= n_chunk;
                r_total     <= n_total;
                r_out_valid <= w_result.valid;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_data_byte;
        end
        if (w_go) begin
            r_out_byte <= w_result.out_byte;
            r_out_kind <= w_result.kind;
        end
    end

endmodule

`default_nettype wire
